// ===== hw/rtl/rfpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpf_pkg
// Shared types and constants for the recent-free pointer filter.
// ----------------------------------------------------------------------------
package rfpf_pkg;

    localparam int unsigned TABLE_SLOTS_DEF = 65536;
    localparam logic [63:0] HASH_MULT       = 64'h0000_0000_7FEB_352D;
    localparam int unsigned PTR_W           = 64;
    localparam int unsigned SLOT_OUT_W      = 16;

    typedef enum logic [1:0] {
        CMD_CHECK    = 2'd0,
        CMD_CLAIM    = 2'd1,
        CMD_REMEMBER = 2'd2,
        CMD_FORGET   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_MODIFY
    } t_state;

endpackage

// ===== hw/rtl/rfpf_ram.sv =====
// ----------------------------------------------------------------------------
// rfpf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rfpf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/recent_free_pointer_filter_unit.sv =====
// ----------------------------------------------------------------------------
// recent_free_pointer_filter_unit
// Direct-mapped table of recently freed pointers for double-free detection.
// ----------------------------------------------------------------------------
// Each transaction carries a command in tuser (check, claim, remember,
// forget) and a 64-bit pointer in tdata, and returns exactly one result with
// a flag and the hashed slot number. The table lives in one single-port RAM
// of TABLE_SLOTS x 64 bits. The result is valid after the hash multiply,
// table read, update and result load steps, and the next request is
// accepted only once the previous one has passed through them and the
// block is back in idle; the single RAM port is used for the read and then
// the write back of the same slot. A result waiting on the output does not
// block acceptance of the next request, which then holds in the update
// stage until the output frees. After reset the RAM is swept to zero one
// entry per cycle over all TABLE_SLOTS entries, with s_axis_tready held low.
// ----------------------------------------------------------------------------
module recent_free_pointer_filter_unit #(
    parameter int unsigned TABLE_SLOTS = rfpf_pkg::TABLE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] pointer
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] flag, [16:1] slot_index, [23:17] zero
);

    import rfpf_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SLOTS);
    localparam int unsigned MW = AW + 15;
    localparam logic [AW-1:0] SlotMask = AW'(TABLE_SLOTS - 1);
    localparam logic [MW-1:0] MultC    = MW'(HASH_MULT);

    t_state r_state, n_state;

    t_cmd             r_cmd;
    logic [PTR_W-1:0] r_ptr;
    logic [MW-1:0]    r_prod;
    logic [AW-1:0]    r_slot;
    logic [AW-1:0]    r_clr_addr;

    logic                  r_out_valid;
    logic                  r_out_flag;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    logic [PTR_W-1:0] hash_h0;
    logic [PTR_W-1:0] hash_h1;
    logic [MW-1:0]    hash_x;
    logic [AW-1:0]    slot_calc;
    logic [AW+SLOT_OUT_W-1:0] slot_ext;

    logic             in_accept;
    logic             out_free;
    logic             ptr_nz;
    logic             held_eq;
    logic             mod_flag;
    logic             mod_we;
    logic [PTR_W-1:0] mod_data;

    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [PTR_W-1:0] ram_wdata;
    logic [PTR_W-1:0] ram_rdata;

    rfpf_ram #(
        .WIDTH (PTR_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    // hash front end: only low MW product bits reach the slot
    assign hash_h0 = r_ptr >> 3;
    assign hash_h1 = hash_h0 ^ (hash_h0 >> 16);
    assign hash_x  = hash_h1[MW-1:0];

    assign slot_calc = (r_prod[AW-1:0] ^ r_prod[AW+14:15]) & SlotMask;
    assign slot_ext  = {{SLOT_OUT_W{1'b0}}, r_slot};

    assign ptr_nz  = (r_ptr != '0);
    assign held_eq = (ram_rdata == r_ptr);

    always_comb begin
        mod_flag = 1'b0;
        mod_we   = 1'b0;
        mod_data = r_ptr;
        case (r_cmd)
            CMD_CHECK: begin
                mod_flag = ptr_nz && held_eq;
            end
            CMD_CLAIM: begin
                mod_flag = !held_eq;
                mod_we   = 1'b1;
            end
            CMD_REMEMBER: begin
                mod_we = ptr_nz;
            end
            CMD_FORGET: begin
                mod_we   = ptr_nz && held_eq;
                mod_data = '0;
            end
            default: begin
                mod_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SlotMask) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) n_state = ST_HASH;
            end
            ST_HASH: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs and RAM port
    always_comb begin
        s_axis_tready = 1'b0;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = r_slot;
        ram_wdata     = mod_data;
        case (r_state)
            ST_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_READ: begin
                ram_en   = 1'b1;
                ram_addr = slot_calc;
            end
            ST_MODIFY: begin
                ram_en = out_free && mod_we;
                ram_we = out_free && mod_we;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_MODIFY && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= t_cmd'(s_axis_tuser);
            r_ptr <= s_axis_tdata;
        end
        if (r_state == ST_HASH) begin
            r_prod <= hash_x * MultC;
        end
        if (r_state == ST_READ) begin
            r_slot <= slot_calc;
        end
        if (r_state == ST_MODIFY && out_free) begin
            r_out_flag <= mod_flag;
            r_out_slot <= slot_ext[SLOT_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_slot, r_out_flag};

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during table clear");

    a_accept_starts_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_HASH))
        else $error("accepted request did not enter hash stage");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_MODIFY))
        else $error("table write outside clear or update");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_MODIFY))
        else $error("result appeared without an update");

    a_modify_waits_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODIFY && !out_free) |=> (r_state == ST_MODIFY))
        else $error("update left while output was blocked");
`endif

endmodule
